[rtl/core/csc_pkg.sv]
// Shared constants and types for the circle and segment contact core.
package csc_pkg;

    localparam int CSC_COORD_BITS  = 12;
    localparam int CSC_RADIUS_BITS = 8;
    localparam int CSC_KIND_BITS   = 2;
    localparam int CSC_STAGES      = 4;
    localparam int CSC_OUT_BYTES   = 1;

    typedef enum logic [CSC_KIND_BITS-1:0] {
        KIND_EDGE   = 2'd0,
        KIND_GOAL   = 2'd1,
        KIND_PADDLE = 2'd2
    } csc_kind_t;

    // Packed so that body_contact sits in bit 0.
    typedef struct packed {
        logic edge_bounce;
        logic second_end_contact;
        logic first_end_contact;
        logic body_contact;
    } csc_result_t;

endpackage

[rtl/core/csc_datapath.sv]
// Four-stage arithmetic pipeline: differences, products, sums, squares, final compare.
module csc_datapath #(
    parameter int COORD_BITS  = csc_pkg::CSC_COORD_BITS,
    parameter int RADIUS_BITS = csc_pkg::CSC_RADIUS_BITS
) (
    input  logic                                  clk,
    input  logic [csc_pkg::CSC_STAGES-1:0]        load,
    input  logic [COORD_BITS-1:0]                 ball_x,
    input  logic [COORD_BITS-1:0]                 ball_y,
    input  logic [RADIUS_BITS-1:0]                radius,
    input  logic [COORD_BITS-1:0]                 seg_x1,
    input  logic [COORD_BITS-1:0]                 seg_y1,
    input  logic [COORD_BITS-1:0]                 seg_x2,
    input  logic [COORD_BITS-1:0]                 seg_y2,
    input  logic [csc_pkg::CSC_KIND_BITS-1:0]     line_kind,
    output csc_pkg::csc_result_t                  result
);
    import csc_pkg::*;

    localparam int C        = COORD_BITS;
    localparam int D_W      = C + 1;
    localparam int S_W      = C + 2;
    localparam int P_W      = 2 * C + 2;
    localparam int Q_W      = 2 * C + 3;
    localparam int SQ_W     = 2 * C;
    localparam int R2_W     = 2 * RADIUS_BITS;
    localparam int X_W      = 2 * C + 3;
    localparam int CM_W     = 2 * C + 2;
    localparam int AS_W     = 2 * C + 4;
    localparam int AM_W     = 2 * C + 3;
    localparam int L_W      = 2 * C + 1;
    localparam int PS_W     = 2 * C + 1;
    localparam int PC_W     = (PS_W > R2_W) ? PS_W : R2_W;
    localparam int CROSS2_W = 2 * CM_W;
    localparam int RL_W     = R2_W + L_W;
    localparam int LINE_W   = (CROSS2_W > RL_W) ? CROSS2_W : RL_W;
    localparam int ALONG2_W = 2 * AM_W;
    localparam int LEN4_W   = 2 * L_W;

    // stage 1: differences
    logic signed [D_W-1:0] dx_reg, dy_reg, ex1_reg, ey1_reg, ex2_reg, ey2_reg;
    logic signed [D_W-1:0] dx_next, dy_next, ex1_next, ey1_next, ex2_next, ey2_next;
    logic signed [S_W-1:0] sx_reg, sy_reg, sx_next, sy_next;
    logic [RADIUS_BITS-1:0] r1_reg;
    logic                  edge1_reg, edge1_next;

    // stage 2: products
    logic signed [P_W-1:0] pa_reg, pb_reg, pa_next, pb_next;
    logic signed [Q_W-1:0] pc_reg, pd_reg, pc_next, pd_next;
    logic signed [P_W-1:0] dxsq_full, dysq_full, q1x_full, q1y_full, q2x_full, q2y_full;
    logic [SQ_W-1:0]       dxsq_reg, dysq_reg, q1x_reg, q1y_reg, q2x_reg, q2y_reg;
    logic [R2_W-1:0]       r2_reg, r2_next;
    logic                  edge2_reg;

    // stage 3: sums and magnitudes
    logic signed [X_W-1:0]  cross_s, cross_abs;
    logic signed [AS_W-1:0] along_s, along_abs;
    logic [CM_W-1:0]        cross_reg, cross_next;
    logic [AM_W-1:0]        along_reg, along_next;
    logic [L_W-1:0]         len2_reg, len2_next;
    logic [PS_W-1:0]        psum1, psum2;
    logic [R2_W-1:0]        r2b_reg;
    logic                   in1_reg, in2_reg, in1_next, in2_next, edge3_reg;

    // stage 4: squares
    logic [CROSS2_W-1:0] cross2_reg, cross2_next;
    logic [RL_W-1:0]     rlen_reg, rlen_next;
    logic [ALONG2_W-1:0] along2_reg, along2_next;
    logic [LEN4_W-1:0]   len4_reg, len4_next;
    logic                nz_reg, nz_next, in1b_reg, in2b_reg, edge4_reg;

    logic line_ok, bis_ok, body;

    always_comb
    begin
        dx_next    = signed'({1'b0, seg_x2}) - signed'({1'b0, seg_x1});
        dy_next    = signed'({1'b0, seg_y2}) - signed'({1'b0, seg_y1});
        ex1_next   = signed'({1'b0, ball_x}) - signed'({1'b0, seg_x1});
        ey1_next   = signed'({1'b0, ball_y}) - signed'({1'b0, seg_y1});
        ex2_next   = signed'({1'b0, ball_x}) - signed'({1'b0, seg_x2});
        ey2_next   = signed'({1'b0, ball_y}) - signed'({1'b0, seg_y2});
        sx_next    = signed'({1'b0, ball_x, 1'b0}) - signed'({2'b00, seg_x1})
                     - signed'({2'b00, seg_x2});
        sy_next    = signed'({1'b0, ball_y, 1'b0}) - signed'({2'b00, seg_y1})
                     - signed'({2'b00, seg_y2});
        edge1_next = (csc_kind_t'(line_kind) == KIND_EDGE);
    end

    always_comb
    begin
        pa_next   = P_W'(dy_reg) * P_W'(ex1_reg);
        pb_next   = P_W'(dx_reg) * P_W'(ey1_reg);
        pc_next   = Q_W'(dx_reg) * Q_W'(sx_reg);
        pd_next   = Q_W'(dy_reg) * Q_W'(sy_reg);
        dxsq_full = P_W'(dx_reg) * P_W'(dx_reg);
        dysq_full = P_W'(dy_reg) * P_W'(dy_reg);
        q1x_full  = P_W'(ex1_reg) * P_W'(ex1_reg);
        q1y_full  = P_W'(ey1_reg) * P_W'(ey1_reg);
        q2x_full  = P_W'(ex2_reg) * P_W'(ex2_reg);
        q2y_full  = P_W'(ey2_reg) * P_W'(ey2_reg);
        r2_next   = R2_W'(r1_reg) * R2_W'(r1_reg);
    end

    always_comb
    begin
        cross_s    = X_W'(pa_reg) - X_W'(pb_reg);
        cross_abs  = cross_s[X_W-1] ? -cross_s : cross_s;
        cross_next = cross_abs[CM_W-1:0];
        along_s    = AS_W'(pc_reg) + AS_W'(pd_reg);
        along_abs  = along_s[AS_W-1] ? -along_s : along_s;
        along_next = along_abs[AM_W-1:0];
        len2_next  = L_W'(dxsq_reg) + L_W'(dysq_reg);
        psum1      = PS_W'(q1x_reg) + PS_W'(q1y_reg);
        psum2      = PS_W'(q2x_reg) + PS_W'(q2y_reg);
        in1_next   = PC_W'(psum1) <= PC_W'(r2_reg);
        in2_next   = PC_W'(psum2) <= PC_W'(r2_reg);
    end

    always_comb
    begin
        cross2_next = CROSS2_W'(cross_reg) * CROSS2_W'(cross_reg);
        rlen_next   = RL_W'(r2b_reg) * RL_W'(len2_reg);
        along2_next = ALONG2_W'(along_reg) * ALONG2_W'(along_reg);
        len4_next   = LEN4_W'(len2_reg) * LEN4_W'(len2_reg);
        nz_next     = (len2_reg != '0);
    end

    always_ff @(posedge clk)
    begin
        if (load[0])
        begin
            dx_reg    <= dx_next;
            dy_reg    <= dy_next;
            ex1_reg   <= ex1_next;
            ey1_reg   <= ey1_next;
            ex2_reg   <= ex2_next;
            ey2_reg   <= ey2_next;
            sx_reg    <= sx_next;
            sy_reg    <= sy_next;
            r1_reg    <= radius;
            edge1_reg <= edge1_next;
        end
        if (load[1])
        begin
            pa_reg    <= pa_next;
            pb_reg    <= pb_next;
            pc_reg    <= pc_next;
            pd_reg    <= pd_next;
            dxsq_reg  <= dxsq_full[SQ_W-1:0];
            dysq_reg  <= dysq_full[SQ_W-1:0];
            q1x_reg   <= q1x_full[SQ_W-1:0];
            q1y_reg   <= q1y_full[SQ_W-1:0];
            q2x_reg   <= q2x_full[SQ_W-1:0];
            q2y_reg   <= q2y_full[SQ_W-1:0];
            r2_reg    <= r2_next;
            edge2_reg <= edge1_reg;
        end
        if (load[2])
        begin
            cross_reg <= cross_next;
            along_reg <= along_next;
            len2_reg  <= len2_next;
            r2b_reg   <= r2_reg;
            in1_reg   <= in1_next;
            in2_reg   <= in2_next;
            edge3_reg <= edge2_reg;
        end
        if (load[3])
        begin
            cross2_reg <= cross2_next;
            rlen_reg   <= rlen_next;
            along2_reg <= along2_next;
            len4_reg   <= len4_next;
            nz_reg     <= nz_next;
            in1b_reg   <= in1_reg;
            in2b_reg   <= in2_reg;
            edge4_reg  <= edge3_reg;
        end
    end

    always_comb
    begin
        line_ok                   = LINE_W'(cross2_reg) <= LINE_W'(rlen_reg);
        bis_ok                    = along2_reg <= ALONG2_W'(len4_reg);
        body                      = nz_reg && line_ok && bis_ok;
        result.body_contact       = body;
        result.first_end_contact  = !body && in1b_reg;
        result.second_end_contact = !body && in2b_reg;
        result.edge_bounce        = body && edge4_reg;
    end

endmodule

[rtl/core/circle_segment_contact_core.sv]
// Top level of the circle and segment contact core: stream handshake and pipeline control.
//
//  channel | dir | transaction payload
//  --------+-----+-------------------------------------------------------------
//  s_      | in  | circle center, radius, segment endpoints (tdata), kind (tuser)
//  m_      | out | body, first end, second end, edge bounce flags (tdata)
//
//  One transaction per cycle is taken while m_ is not stalled. A result
//  reaches m_ through five register stages: the first of the four arithmetic
//  stages, loaded at the accepting edge, the other three, then the output
//  register; the squaring multipliers set the stage depth.
//  rst_n clears only the valid bits; payload registers are not reset.
//  A stalled m_ side holds the output register; each stage still loads when
//  the one after it is empty or moving, so bubbles close up and nothing drops.
module circle_segment_contact_core #(
    parameter int COORD_BITS  = csc_pkg::CSC_COORD_BITS,
    parameter int RADIUS_BITS = csc_pkg::CSC_RADIUS_BITS
) (
    input  logic clk,
    input  logic rst_n,
    input  logic s_tvalid,
    output logic s_tready,
    // ball_x, ball_y, radius, seg_x1, seg_y1, seg_x2, seg_y2, zero fill
    input  logic [((6*COORD_BITS+RADIUS_BITS+7)/8)*8-1:0] s_tdata,
    // line_kind
    input  logic [csc_pkg::CSC_KIND_BITS-1:0] s_tuser,
    output logic m_tvalid,
    input  logic m_tready,
    // body_contact, first_end_contact, second_end_contact, edge_bounce, zero fill
    output logic [csc_pkg::CSC_OUT_BYTES*8-1:0] m_tdata
);
    import csc_pkg::*;

    localparam int C     = COORD_BITS;
    localparam int R     = RADIUS_BITS;
    localparam int RES_W = $bits(csc_result_t);

    logic [CSC_STAGES-1:0] valid_reg, valid_next;
    logic [CSC_STAGES:0]   can_move;
    logic                  out_valid_reg, out_valid_next;
    csc_result_t           out_reg, stage_result;

    // Backpressure chain: a stage moves when its successor is empty or moving.
    always_comb
    begin
        can_move[CSC_STAGES] = !out_valid_reg || m_tready;
        for (int k = CSC_STAGES - 1; k >= 0; k--)
        begin
            can_move[k] = !valid_reg[k] || can_move[k+1];
        end
    end

    assign s_tready = can_move[0];

    // Advance valid bits alongside the data they tag.
    always_comb
    begin
        valid_next     = valid_reg;
        out_valid_next = out_valid_reg;
        if (can_move[0])
        begin
            valid_next[0] = s_tvalid;
        end
        for (int k = 1; k < CSC_STAGES; k++)
        begin
            if (can_move[k])
            begin
                valid_next[k] = valid_reg[k-1];
            end
        end
        if (can_move[CSC_STAGES])
        begin
            out_valid_next = valid_reg[CSC_STAGES-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg     <= valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold the finished result while the sink stalls.
    always_ff @(posedge clk)
    begin
        if (can_move[CSC_STAGES])
        begin
            out_reg <= stage_result;
        end
    end

    csc_datapath #(
        .COORD_BITS  (COORD_BITS),
        .RADIUS_BITS (RADIUS_BITS)
    ) u_datapath (
        .clk       (clk),
        .load      (can_move[CSC_STAGES-1:0]),
        .ball_x    (s_tdata[C-1:0]),
        .ball_y    (s_tdata[2*C-1:C]),
        .radius    (s_tdata[2*C+R-1:2*C]),
        .seg_x1    (s_tdata[3*C+R-1:2*C+R]),
        .seg_y1    (s_tdata[4*C+R-1:3*C+R]),
        .seg_x2    (s_tdata[5*C+R-1:4*C+R]),
        .seg_y2    (s_tdata[6*C+R-1:5*C+R]),
        .line_kind (s_tuser),
        .result    (stage_result)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(CSC_OUT_BYTES*8-RES_W){1'b0}}, out_reg};

endmodule

[rtl/core/csc_checker.sv]
// Port-level assertions for the circle and segment contact core, bound to the top level.
module csc_checker #(
    parameter int COORD_BITS  = csc_pkg::CSC_COORD_BITS,
    parameter int RADIUS_BITS = csc_pkg::CSC_RADIUS_BITS
) (
    input logic clk,
    input logic rst_n,
    input logic s_tvalid,
    input logic s_tready,
    input logic [((6*COORD_BITS+RADIUS_BITS+7)/8)*8-1:0] s_tdata,
    input logic [csc_pkg::CSC_KIND_BITS-1:0] s_tuser,
    input logic m_tvalid,
    input logic m_tready,
    input logic [csc_pkg::CSC_OUT_BYTES*8-1:0] m_tdata
);
    import csc_pkg::*;

    csc_result_t res;
    assign res = csc_result_t'(m_tdata[$bits(csc_result_t)-1:0]);

    // A stalled input transaction holds.
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata) && $stable(s_tuser))
        else $error("stalled input changed");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // Endpoint flags only without body contact.
    a_end_excl: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(res.body_contact &&
                       (res.first_end_contact || res.second_end_contact)))
        else $error("endpoint contact flagged together with body contact");

    // Bounce needs body contact.
    a_bounce_body: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && res.edge_bounce |-> res.body_contact)
        else $error("edge bounce without body contact");

    // With the output register empty nothing may hold the input back.
    a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled while output empty");

endmodule

bind circle_segment_contact_core csc_checker #(
    .COORD_BITS  (COORD_BITS),
    .RADIUS_BITS (RADIUS_BITS)
) u_csc_checker (.*);

[bench/tb_circle_segment_contact_core.sv]
// Self-checking testbench for circle_segment_contact_core: random and directed contact tests.
`timescale 1ns / 1ps

module tb_circle_segment_contact_core;
    import csc_pkg::*;

    localparam int COORD_W     = CSC_COORD_BITS;
    localparam int RADIUS_W    = CSC_RADIUS_BITS;
    localparam int TDATA_W     = ((6*COORD_W+RADIUS_W+7)/8)*8;
    localparam int RESULT_W    = CSC_OUT_BYTES*8;
    localparam int COORD_MAX   = (1 << COORD_W) - 1;
    localparam int RADIUS_MAX  = (1 << RADIUS_W) - 1;
    localparam int RANDOM_ITEMS = 1750;
    localparam int IDLE_PCT    = 18;
    // window with no idling on either side
    localparam int QUIET_FROM  = 1000;
    localparam int QUIET_TO    = 1800;
    localparam int DRAIN_CYCLES = 12;
    localparam int CYCLE_LIMIT = 200000;
    // code 3 is not a named kind; the block treats it like goal or paddle
    localparam logic [CSC_KIND_BITS-1:0] KIND_UNUSED = 2'd3;

    typedef struct {
        logic [COORD_W-1:0]       bx;
        logic [COORD_W-1:0]       by;
        logic [RADIUS_W-1:0]      r;
        logic [COORD_W-1:0]       x1;
        logic [COORD_W-1:0]       y1;
        logic [COORD_W-1:0]       x2;
        logic [COORD_W-1:0]       y2;
        logic [CSC_KIND_BITS-1:0] kind;
    } contact_item_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     s_tvalid = 1'b0;
    logic                     s_tready;
    // ball_x, ball_y, radius, seg_x1, seg_y1, seg_x2, seg_y2, zero fill
    logic [TDATA_W-1:0]       s_tdata = '0;
    // line_kind
    logic [CSC_KIND_BITS-1:0] s_tuser = '0;
    logic                     m_tvalid;
    logic                     m_tready = 1'b0;
    // body_contact, first_end_contact, second_end_contact, edge_bounce, zero fill
    logic [RESULT_W-1:0]      m_tdata;

    contact_item_t pending_items[$];
    csc_result_t   expected_flags[$];
    contact_item_t item_on_bus;
    int            total_items;
    int            accepted_items = 0;
    int            result_count = 0;
    int            mismatches = 0;
    int            cycle_count = 0;

    circle_segment_contact_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #6 clk = ~clk;

    // Exact integer contact test; every product fits in 64 bits at these widths.
    function automatic csc_result_t predict_contact(contact_item_t it);
        longint bx, by, x1, y1, x2, y2, r, dx, dy, len2, cross_term, along;
        bit body, in1, in2;
        csc_result_t res;
        bx = it.bx;
        by = it.by;
        x1 = it.x1;
        y1 = it.y1;
        x2 = it.x2;
        y2 = it.y2;
        r  = it.r;
        dx = x2 - x1;
        dy = y2 - y1;
        len2 = dx*dx + dy*dy;
        body = 1'b0;
        // a zero-length segment has no body
        if (len2 != 0)
        begin
            cross_term = dy*(bx - x1) - dx*(by - y1);
            along = dx*(2*bx - x1 - x2) + dy*(2*by - y1 - y2);
            body = (cross_term*cross_term <= r*r*len2) && (along*along <= len2*len2);
        end
        in1 = (bx - x1)*(bx - x1) + (by - y1)*(by - y1) <= r*r;
        in2 = (bx - x2)*(bx - x2) + (by - y2)*(by - y2) <= r*r;
        res.body_contact       = body;
        res.first_end_contact  = !body && in1;
        res.second_end_contact = !body && in2;
        res.edge_bounce        = body && (it.kind == KIND_EDGE);
        return res;
    endfunction

    function automatic logic [COORD_W-1:0] clamp_coord(int v);
        if (v < 0)
            return '0;
        if (v > COORD_MAX)
            return COORD_W'(COORD_MAX);
        return COORD_W'(v);
    endfunction

    function automatic int rand_offset(int k);
        return int'($urandom_range(0, 2*k)) - k;
    endfunction

    function automatic logic [COORD_W-1:0] extreme_coord();
        int pick;
        pick = $urandom_range(0, 2);
        if (pick == 0)
            return '0;
        if (pick == 1)
            return COORD_W'(COORD_MAX);
        return COORD_W'($urandom);
    endfunction

    // Mostly near-miss geometry so that contact, tangency and bisector edges show up often.
    function automatic contact_item_t random_contact_item();
        contact_item_t it;
        int mode, r, span, t, x1, y1, x2, y2;
        mode = $urandom_range(0, 99);
        r = ($urandom_range(0, 9) == 0) ? int'($urandom_range(200, RADIUS_MAX))
                                        : int'($urandom_range(0, 80));
        it.kind = CSC_KIND_BITS'($urandom_range(0, 3));
        it.r = RADIUS_W'(r);
        if (mode < 20)
        begin
            // anything the fields allow
            it.bx = COORD_W'($urandom);
            it.by = COORD_W'($urandom);
            it.r  = RADIUS_W'($urandom);
            it.x1 = COORD_W'($urandom);
            it.y1 = COORD_W'($urandom);
            it.x2 = COORD_W'($urandom);
            it.y2 = COORD_W'($urandom);
        end
        else if (mode < 70)
        begin
            // center near the segment, somewhat past either end too
            span = ($urandom_range(0, 7) == 0) ? COORD_MAX : 400;
            x1 = $urandom_range(0, COORD_MAX);
            y1 = $urandom_range(0, COORD_MAX);
            x2 = clamp_coord(x1 + rand_offset(span));
            y2 = clamp_coord(y1 + rand_offset(span));
            t = int'($urandom_range(0, 96)) - 16;
            it.x1 = COORD_W'(x1);
            it.y1 = COORD_W'(y1);
            it.x2 = COORD_W'(x2);
            it.y2 = COORD_W'(y2);
            it.bx = clamp_coord(x1 + (t*(x2 - x1))/64 + rand_offset(r + 20));
            it.by = clamp_coord(y1 + (t*(y2 - y1))/64 + rand_offset(r + 20));
        end
        else if (mode < 85)
        begin
            // first endpoint around the rim of the circle, the second too half the time
            it.bx = COORD_W'($urandom);
            it.by = COORD_W'($urandom);
            it.x1 = clamp_coord(int'(it.bx) + rand_offset(r + 8));
            it.y1 = clamp_coord(int'(it.by) + rand_offset(r + 8));
            if ($urandom_range(0, 1) == 0)
            begin
                it.x2 = clamp_coord(int'(it.bx) + rand_offset(r + 8));
                it.y2 = clamp_coord(int'(it.by) + rand_offset(r + 8));
            end
            else
            begin
                it.x2 = COORD_W'($urandom);
                it.y2 = COORD_W'($urandom);
            end
        end
        else if (mode < 93)
        begin
            // zero-length segment near the center
            it.bx = COORD_W'($urandom);
            it.by = COORD_W'($urandom);
            it.x1 = clamp_coord(int'(it.bx) + rand_offset(r + 4));
            it.y1 = clamp_coord(int'(it.by) + rand_offset(r + 4));
            it.x2 = it.x1;
            it.y2 = it.y1;
        end
        else
        begin
            it.bx = extreme_coord();
            it.by = extreme_coord();
            it.x1 = extreme_coord();
            it.y1 = extreme_coord();
            it.x2 = extreme_coord();
            it.y2 = extreme_coord();
            it.r  = ($urandom_range(0, 1) == 0) ? RADIUS_W'(RADIUS_MAX) : '0;
        end
        return it;
    endfunction

    task automatic add_item(int bx, int by, int r, int x1, int y1, int x2, int y2,
                            logic [CSC_KIND_BITS-1:0] kind);
        contact_item_t it;
        it.bx = COORD_W'(bx);
        it.by = COORD_W'(by);
        it.r  = RADIUS_W'(r);
        it.x1 = COORD_W'(x1);
        it.y1 = COORD_W'(y1);
        it.x2 = COORD_W'(x2);
        it.y2 = COORD_W'(y2);
        it.kind = kind;
        pending_items.push_back(it);
    endtask

    task automatic report_mismatch(string what);
        $display("[%0t] result %0d mismatch: %s", $realtime, result_count, what);
        mismatches++;
    endtask

    function automatic bit idle_now();
        return (cycle_count < QUIET_FROM || cycle_count > QUIET_TO) &&
               ($urandom_range(0, 99) < IDLE_PCT);
    endfunction

    // Source side: log each accepted transaction, then load the next item or idle.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                expected_flags.push_back(predict_contact(item_on_bus));
                accepted_items++;
            end
            // hold the payload while the block stalls
            if (!s_tvalid || s_tready)
            begin
                if (pending_items.size() != 0 && !idle_now())
                begin
                    item_on_bus = pending_items.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {item_on_bus.y2, item_on_bus.x2, item_on_bus.y1,
                                 item_on_bus.x1, item_on_bus.r, item_on_bus.by,
                                 item_on_bus.bx};
                    s_tuser  <= item_on_bus.kind;
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Sink side: compare each accepted result against the oldest prediction.
    always @(posedge clk or negedge rst_n)
    begin
        csc_result_t got, want;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got = csc_result_t'(m_tdata[$bits(csc_result_t)-1:0]);
                if (expected_flags.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected result %h", m_tdata));
                end
                else
                begin
                    want = expected_flags.pop_front();
                    if (got.body_contact !== want.body_contact)
                        report_mismatch($sformatf("body_contact %b, want %b",
                                                  got.body_contact, want.body_contact));
                    if (got.first_end_contact !== want.first_end_contact)
                        report_mismatch($sformatf("first_end_contact %b, want %b",
                                                  got.first_end_contact,
                                                  want.first_end_contact));
                    if (got.second_end_contact !== want.second_end_contact)
                        report_mismatch($sformatf("second_end_contact %b, want %b",
                                                  got.second_end_contact,
                                                  want.second_end_contact));
                    if (got.edge_bounce !== want.edge_bounce)
                        report_mismatch($sformatf("edge_bounce %b, want %b",
                                                  got.edge_bounce, want.edge_bounce));
                    if (m_tdata[RESULT_W-1:$bits(csc_result_t)] !== '0)
                        report_mismatch($sformatf("fill bits not zero in %h", m_tdata));
                end
                result_count++;
            end
            m_tready <= !idle_now();
        end
    end

    // Watchdog: drop the run once the cycle count reaches its limit, so a stalled stream cannot run forever.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    initial
    begin
        // extremes: all zero and all ones, unused kind code
        add_item(0, 0, 0, 0, 0, 0, 0, KIND_EDGE);
        add_item(COORD_MAX, COORD_MAX, RADIUS_MAX, COORD_MAX, COORD_MAX,
                 COORD_MAX, COORD_MAX, KIND_UNUSED);
        // exact tangency to a horizontal segment, once per kind
        add_item(150, 110, 10, 100, 100, 200, 100, KIND_EDGE);
        add_item(150, 110, 10, 100, 100, 200, 100, KIND_GOAL);
        add_item(150, 110, 10, 100, 100, 200, 100, KIND_PADDLE);
        add_item(150, 110, 10, 100, 100, 200, 100, KIND_UNUSED);
        // one pixel past tangency
        add_item(150, 111, 10, 100, 100, 200, 100, KIND_EDGE);
        // center exactly on the bisector band limit, then just outside each end
        add_item(200, 105, 10, 100, 100, 200, 100, KIND_EDGE);
        add_item(201, 105, 10, 100, 100, 200, 100, KIND_EDGE);
        add_item(99, 105, 10, 100, 100, 200, 100, KIND_GOAL);
        // body contact wins over endpoints inside the circle
        add_item(101, 100, 50, 100, 100, 102, 100, KIND_EDGE);
        // both endpoints inside but the center is off the end of the segment
        add_item(110, 100, 20, 100, 100, 104, 100, KIND_PADDLE);
        // zero-length segment on the rim, then just outside it
        add_item(503, 504, 5, 500, 500, 500, 500, KIND_EDGE);
        add_item(503, 504, 4, 500, 500, 500, 500, KIND_EDGE);
        add_item(2000, 2000, 10, 0, 0, 100, 0, KIND_EDGE);
        // full-span diagonal, center one step off the line
        add_item(2048, 2047, 0, 0, 0, COORD_MAX, COORD_MAX, KIND_EDGE);
        add_item(2048, 2047, 1, 0, 0, COORD_MAX, COORD_MAX, KIND_EDGE);
        // full-span vertical at maximum radius, tangent
        add_item(RADIUS_MAX, 2000, RADIUS_MAX, 0, 0, 0, COORD_MAX, KIND_EDGE);
        // corner ball reaching the first endpoint only
        add_item(COORD_MAX, COORD_MAX, RADIUS_MAX, 3915, 3915, 3915, 0, KIND_GOAL);
        // zero radius at the midpoint, and reversed segment direction
        add_item(150, 100, 0, 100, 100, 200, 100, KIND_PADDLE);
        add_item(150, 90, 10, 200, 100, 100, 100, KIND_EDGE);
        repeat (RANDOM_ITEMS)
            pending_items.push_back(random_contact_item());
        total_items = pending_items.size();

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // advance until every item is accepted and every result is back
        while (accepted_items != total_items)
            @(posedge clk);
        while (expected_flags.size() != 0)
            @(posedge clk);
        // keep clocking after the last result to catch stray results
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0 && expected_flags.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

[files.f]
rtl/core/csc_pkg.sv
rtl/core/csc_datapath.sv
rtl/core/circle_segment_contact_core.sv
rtl/core/csc_checker.sv
bench/tb_circle_segment_contact_core.sv
